### hdl/atl_pkg.sv
// package: segment tables and helpers for the adc temperature linearizer
`timescale 1ns / 1ps

package atl_pkg;

  localparam int unsigned SEG_COUNT   = 13;
  localparam int unsigned SEG_IDX_W   = $clog2(SEG_COUNT);
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned SLOPE_W     = 20;
  localparam int unsigned OFF_W       = 10;
  localparam int unsigned PROD_W      = CODE_W + SLOPE_W;
  localparam int unsigned Q_FRAC      = 16;
  localparam int unsigned TENTHS_W    = 11;
  localparam int unsigned TEMP_W      = 8;
  localparam int unsigned FRAC_W      = 4;

  // reciprocal of ten, q16; exact floor for every 11-bit tenths value
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 13'd6554;
  localparam int unsigned DIVP_W      = TENTHS_W + RECIP_W;

  localparam logic [FRAC_W-1:0] FRAC_UP_MIN   = 4'd8;
  localparam logic [FRAC_W-1:0] FRAC_HALF_MIN = 4'd3;

  // lowest code of each segment
  localparam logic [CODE_W-1:0] SEG_BASE [SEG_COUNT] = '{
    8'd11,  8'd31,  8'd54,  8'd74,  8'd85,  8'd97,  8'd110,
    8'd116, 8'd125, 8'd165, 8'd173, 8'd186, 8'd190
  };

  // q16 slope already scaled by ten, so the product lands in tenths
  localparam logic [SLOPE_W-1:0] SEG_SLOPE10 [SEG_COUNT] = '{
    20'd350490, 20'd281800, 20'd325320, 20'd320190, 20'd273070,
    20'd252060, 20'd1026880, 20'd730120, 20'd243370, 20'd414520,
    20'd524500, 20'd257000, 20'd278450
  };

  // temperature at the segment base, in tenths
  localparam logic [OFF_W-1:0] SEG_OFF10 [SEG_COUNT] = '{
    10'd0,   10'd50,  10'd150, 10'd250, 10'd300, 10'd350, 10'd400,
    10'd500, 10'd600, 10'd750, 10'd800, 10'd900, 10'd916
  };

  // highest segment whose base is not above the code
  function automatic logic [SEG_IDX_W-1:0] seg_pick(input logic [CODE_W-1:0] code);
    logic [SEG_IDX_W-1:0] s;
    s = '0;
    for (int i = 1; i < SEG_COUNT; i++) begin
      if (code >= SEG_BASE[i]) begin
        s = SEG_IDX_W'(i);
      end
    end
    return s;
  endfunction

endpackage

### hdl/adc_temperature_linearizer_unit.sv
// top level: three-stage pipelined adc code to half-degree temperature mapper
`timescale 1ns / 1ps

//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_adc_code         | input item
//  out     | out_valid, out_ready, out_temp_half_c,  | result item
//          | out_below_range                         |
//
//  one item per cycle sustained while out_ready stays high; an accepted item is registered in each stage in turn
//  stages: input register, segment multiply into tenths, rounding to half degrees
//  synchronous active-low reset clears the stage valid bits only
//  a stall on out_ready holds the output stage; items behind it move up into empty stages,
//  so up to three items sit in the pipe before in_ready drops

module adc_temperature_linearizer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [atl_pkg::CODE_W-1:0]  in_adc_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [atl_pkg::TEMP_W-1:0]  out_temp_half_c,
  output logic                        out_below_range
);

  import atl_pkg::*;

  // stage valid bits
  logic a_valid_r, b_valid_r, out_valid_r;
  logic a_free, b_free, c_free;

  // stage a: captured code
  logic [CODE_W-1:0]   a_code_r;

  // stage b: tenths value and range flag
  logic [TENTHS_W-1:0] b_tenths_r, b_tenths_nxt;
  logic                b_below_r, b_below_nxt;

  // stage c: result
  logic [TEMP_W-1:0]   out_temp_r, out_temp_nxt;
  logic                out_below_r;

  // segment math signals
  logic [SEG_IDX_W-1:0] seg;
  logic [CODE_W-1:0]    delta;
  logic [PROD_W-1:0]    prod;
  logic [TENTHS_W:0]    tenths_sum;

  // rounding signals
  logic [DIVP_W-1:0]    divp;
  logic [TEMP_W-1:0]    whole;
  logic [TENTHS_W-1:0]  whole_x10;
  logic [TENTHS_W-1:0]  frac_full;
  logic [FRAC_W-1:0]    frac;

  // flow control: a stage moves on when the next one is empty or moving
  assign c_free   = !out_valid_r || out_ready;
  assign b_free   = !b_valid_r || c_free;
  assign a_free   = !a_valid_r || b_free;
  assign in_ready = a_free;

  assign out_valid       = out_valid_r;
  assign out_temp_half_c = out_temp_r;
  assign out_below_range = out_below_r;

  // segment select, offset from base and constant-slope multiply
  always_comb begin
    seg         = seg_pick(a_code_r);
    delta       = a_code_r - SEG_BASE[seg];
    prod        = PROD_W'(delta) * PROD_W'(SEG_SLOPE10[seg]);
    tenths_sum  = (TENTHS_W+1)'(SEG_OFF10[seg]) + (TENTHS_W+1)'(prod[PROD_W-1:Q_FRAC]);
    b_below_nxt = (a_code_r < SEG_BASE[0]);
    // codes under the first base saturate to zero
    b_tenths_nxt = b_below_nxt ? '0 : tenths_sum[TENTHS_W-1:0];
  end

  // tenths to half degrees: .0-.2 down, .3-.7 to .5, .8-.9 up
  always_comb begin
    divp      = DIVP_W'(b_tenths_r) * DIVP_W'(DIV10_RECIP);
    whole     = divp[Q_FRAC +: TEMP_W];
    whole_x10 = TENTHS_W'({whole, 3'b000}) + TENTHS_W'({whole, 1'b0});
    frac_full = b_tenths_r - whole_x10;
    frac      = frac_full[FRAC_W-1:0];
    out_temp_nxt = {whole[TEMP_W-2:0], 1'b0};
    if (frac >= FRAC_UP_MIN) begin
      out_temp_nxt = out_temp_nxt + TEMP_W'(2);
    end else if (frac >= FRAC_HALF_MIN) begin
      out_temp_nxt = out_temp_nxt + TEMP_W'(1);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_r <= in_valid;
      end
      if (b_free) begin
        b_valid_r <= a_valid_r;
      end
      if (c_free) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && a_free) begin
      a_code_r <= in_adc_code;
    end
    if (a_valid_r && b_free) begin
      b_tenths_r <= b_tenths_nxt;
      b_below_r  <= b_below_nxt;
    end
    if (b_valid_r && c_free) begin
      out_temp_r  <= out_temp_nxt;
      out_below_r <= b_below_r;
    end
  end

endmodule

### bench/tb_top.sv
// testbench: random and directed code stream checked against a segment-table temperature predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_SEGS     = 13;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RAND_PER_PH  = 100;

  typedef struct packed {
    logic [atl_pkg::TEMP_W-1:0] temp_half_c;
    logic                       below_range;
  } temp_result_t;

  typedef struct {
    int unsigned lo_code;
    int unsigned slope_q16;
    int unsigned off_tenths;
  } segment_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [atl_pkg::CODE_W-1:0]  in_adc_code;
  logic                        out_valid;
  logic                        out_ready;
  logic [atl_pkg::TEMP_W-1:0]  out_temp_half_c;
  logic                        out_below_range;

  logic [atl_pkg::CODE_W-1:0]  pending_codes [$];
  temp_result_t                expected_temps [$];
  logic                        code_taken;
  int unsigned                 sender_idle_pct;
  int unsigned                 recv_stall_pct;
  int unsigned                 cycle_count;
  int unsigned                 error_count;

  adc_temperature_linearizer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_adc_code     (in_adc_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_temp_half_c (out_temp_half_c),
    .out_below_range (out_below_range)
  );

  // clock: 2 ns high, 2 ns low
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // breakpoints of the thirteen segments: lowest code, q16 slope, temperature at base in tenths
  function automatic segment_t segment_of(input int unsigned idx);
    segment_t s;
    case (idx)
      0:       s = '{11,   35049,   0};
      1:       s = '{31,   28180,  50};
      2:       s = '{54,   32532, 150};
      3:       s = '{74,   32019, 250};
      4:       s = '{85,   27307, 300};
      5:       s = '{97,   25206, 350};
      6:       s = '{110, 102688, 400};
      7:       s = '{116,  73012, 500};
      8:       s = '{125,  24337, 600};
      9:       s = '{165,  41452, 750};
      10:      s = '{173,  52450, 800};
      11:      s = '{186,  25700, 900};
      default: s = '{190,  27845, 916};
    endcase
    return s;
  endfunction

  // code to half-degree temperature: segment lookup, multiply into tenths, round to halves
  function automatic temp_result_t linearize_code(input logic [atl_pkg::CODE_W-1:0] code);
    temp_result_t r;
    segment_t     seg;
    int unsigned  tenths;
    int unsigned  halves;
    r.temp_half_c = '0;
    r.below_range = 1'b1;
    seg = segment_of(0);
    // codes under the first base saturate to zero with the flag set
    if (code < seg.lo_code) begin
      return r;
    end
    // highest segment whose base does not exceed the code; 255 lands in the last one
    for (int i = 1; i < NUM_SEGS; i++) begin
      if (code >= segment_of(i).lo_code) begin
        seg = segment_of(i);
      end
    end
    tenths = seg.off_tenths + (((int'(code) - seg.lo_code) * seg.slope_q16 * 10) >> 16);
    halves = (tenths / 10) * 2;
    // tenths 8..9 round up a whole degree, 3..7 become half a degree, 0..2 drop
    if (tenths % 10 >= 8) begin
      halves += 2;
    end else if (tenths % 10 >= 3) begin
      halves += 1;
    end
    r.temp_half_c = halves[atl_pkg::TEMP_W-1:0];
    r.below_range = 1'b0;
    return r;
  endfunction

  // driver: inputs move on the falling edge; a held item stays until it is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || code_taken) begin
        if (pending_codes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid    <= 1'b1;
          in_adc_code <= pending_codes.pop_front();
        end else begin
          in_valid    <= 1'b0;
          in_adc_code <= 8'($urandom);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: handshakes sampled on the rising edge, before the block updates
  always @(posedge clk) begin
    temp_result_t want;
    cycle_count <= cycle_count + 1;
    code_taken  <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_temps.push_back(linearize_code(in_adc_code));
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_temps.size() == 0) begin
          $error("unexpected result item: temp_half_c %0d below_range %0b",
                 out_temp_half_c, out_below_range);
          error_count++;
        end else begin
          want = expected_temps.pop_front();
          if (out_temp_half_c !== want.temp_half_c) begin
            $error("temp_half_c: expected %0d, actual %0d", want.temp_half_c, out_temp_half_c);
            error_count++;
          end
          if (out_below_range !== want.below_range) begin
            $error("below_range: expected %0b, actual %0b", want.below_range, out_below_range);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog for a hung pipe
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // random code, a quarter of the time just around a segment boundary
  function automatic logic [atl_pkg::CODE_W-1:0] random_code();
    int c;
    if ($urandom_range(3) == 0) begin
      c = int'(segment_of($urandom_range(NUM_SEGS - 1)).lo_code) + $urandom_range(2) - 1;
      return 8'(c);
    end
    return 8'($urandom);
  endfunction

  initial begin
    int unsigned sender_pcts [4];
    int unsigned recv_pcts [4];
    sender_pcts = '{0, 45, 0, 17};
    recv_pcts   = '{0, 0, 45, 17};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_adc_code     = '0;
    out_ready       = 1'b0;
    code_taken      = 1'b0;
    cycle_count     = 0;
    error_count     = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: range ends, saturation edge, every segment base, neighbors of several bases, top code
    pending_codes = '{8'd0, 8'd10, 8'd11, 8'd12, 8'd30, 8'd31, 8'd53, 8'd54, 8'd74,
                      8'd85, 8'd97, 8'd109, 8'd110, 8'd116, 8'd125, 8'd164, 8'd165,
                      8'd173, 8'd186, 8'd189, 8'd190, 8'd254, 8'd255, 8'h55, 8'hAA};

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = sender_pcts[ph];
      recv_stall_pct  = recv_pcts[ph];
      for (int n = 0; n < RAND_PER_PH; n++) begin
        pending_codes.push_back(random_code());
      end
      while (pending_codes.size() > 0 || in_valid || expected_temps.size() > 0) begin
        @(posedge clk);
      end
    end

    // let the pipe settle so a stray result still gets flagged
    out_ready <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_temps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
